FILE: hdl/cre_pkg.sv
package cre_pkg;

  // default depth of the record queue between front and back
  localparam int unsigned CRE_FIFO_DEPTH = 4;

  // one classified record, ready to be serialized
  typedef struct packed {
    logic [31:0] source;
    logic [31:0] count;
    logic [31:0] gap;
    logic [1:0]  src_len_m1;
    logic [1:0]  cnt_len_m1;
    logic [1:0]  gap_len_m1;
    logic        gap_nz;
    logic [7:0]  ctrl;
  } cre_rec_t;

endpackage

FILE: hdl/cre_front.sv
module cre_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [31:0]       in_target_block,
  input  logic [31:0]       in_source_block,
  input  logic [31:0]       in_block_count,
  input  logic              q_full,
  output logic              q_wr,
  output cre_pkg::cre_rec_t q_wdata
);
  import cre_pkg::*;

  localparam logic [31:0] Lim4 = 32'h0100_0000;
  localparam logic [31:0] Lim3 = 32'h0001_0000;
  localparam logic [31:0] Lim2 = 32'h0000_0100;

  logic [31:0] next_target_r;
  logic [31:0] next_target_nxt;
  logic [31:0] gap;
  logic [1:0]  src_m1;
  logic [1:0]  cnt_m1;
  logic [1:0]  gap_m1;
  logic        gap_nz;

  // byte count minus one of a value, at least one byte
  function automatic logic [1:0] len_m1(input logic [31:0] v);
    logic [1:0] l;
    if (v >= Lim4) begin
      l = 2'd3;
    end else if (v >= Lim3) begin
      l = 2'd2;
    end else if (v >= Lim2) begin
      l = 2'd1;
    end else begin
      l = 2'd0;
    end
    return l;
  endfunction

  assign q_wr = push && !q_full;

  // classify: gap against the remembered target, field lengths, control byte
  always_comb begin
    gap    = in_target_block - next_target_r;
    gap_nz = (gap != 32'd0);
    src_m1 = len_m1(in_source_block);
    cnt_m1 = len_m1(in_block_count);
    gap_m1 = gap_nz ? len_m1(gap) : 2'd0;
    next_target_nxt = in_target_block + in_block_count;

    q_wdata.source     = in_source_block;
    q_wdata.count      = in_block_count;
    q_wdata.gap        = gap;
    q_wdata.src_len_m1 = src_m1;
    q_wdata.cnt_len_m1 = cnt_m1;
    q_wdata.gap_len_m1 = gap_m1;
    q_wdata.gap_nz     = gap_nz;
    q_wdata.ctrl       = {src_m1, cnt_m1, gap_m1, gap_nz, 1'b0};
  end

  // next target after each accepted record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_target_r <= 32'd0;
    end else if (q_wr) begin
      next_target_r <= next_target_nxt;
    end
  end

endmodule

FILE: hdl/cre_fifo.sv
module cre_fifo #(
  parameter int unsigned DEPTH = cre_pkg::CRE_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  cre_pkg::cre_rec_t wdata,
  output logic              full,
  input  logic              rd,
  output cre_pkg::cre_rec_t rdata,
  output logic              nonempty
);
  import cre_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cre_rec_t        mem_r [DEPTH];
  logic [PtrW-1:0] wp_r;
  logic [PtrW-1:0] rp_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            do_wr;
  logic            do_rd;

  assign full     = (cnt_r == CntFull);
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem_r[rp_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wp_r <= (wp_r == PtrLast) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PtrLast) ? '0 : rp_r + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/cre_back.sv
module cre_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cre_pkg::cre_rec_t head,
  input  logic              head_valid,
  output logic              head_rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_last_byte
);
  import cre_pkg::*;

  localparam logic [1:0] PH_SRC = 2'd0;
  localparam logic [1:0] PH_CNT = 2'd1;
  localparam logic [1:0] PH_GAP = 2'd2;

  cre_rec_t   cur_r;
  cre_rec_t   cur_nxt;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       busy_r;
  logic       busy_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       last_r;
  logic       last_nxt;
  logic       valid_r;
  logic       adv;
  logic       produce;
  logic [31:0] val;
  logic [7:0] sel;

  assign empty         = !valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;
  assign adv           = !valid_r || pop;
  assign produce       = busy_r || head_valid;
  assign head_rd       = adv && !busy_r && head_valid;

  // pick the field being sent and its current byte
  always_comb begin
    case (phase_r)
      PH_SRC:  val = cur_r.source;
      PH_CNT:  val = cur_r.count;
      default: val = cur_r.gap;
    endcase
    case (idx_r)
      2'd3:    sel = val[31:24];
      2'd2:    sel = val[23:16];
      2'd1:    sel = val[15:8];
      default: sel = val[7:0];
    endcase
  end

  // byte sequencer: control byte, then source, count and nonzero gap, msb first
  always_comb begin
    cur_nxt   = cur_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    byte_nxt  = sel;
    last_nxt  = 1'b0;
    if (busy_r) begin
      if (idx_r != 2'd0) begin
        idx_nxt = idx_r - 1'b1;
      end else begin
        case (phase_r)
          PH_SRC: begin
            phase_nxt = PH_CNT;
            idx_nxt   = cur_r.cnt_len_m1;
          end
          PH_CNT: begin
            if (cur_r.gap_nz) begin
              phase_nxt = PH_GAP;
              idx_nxt   = cur_r.gap_len_m1;
            end else begin
              busy_nxt = 1'b0;
              last_nxt = 1'b1;
            end
          end
          default: begin
            busy_nxt = 1'b0;
            last_nxt = 1'b1;
          end
        endcase
      end
    end else begin
      // start of a record: control byte straight from the queue head
      cur_nxt   = head;
      byte_nxt  = head.ctrl;
      phase_nxt = PH_SRC;
      idx_nxt   = head.src_len_m1;
      busy_nxt  = 1'b1;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      phase_r <= PH_SRC;
      idx_r   <= 2'd0;
    end else if (adv) begin
      valid_r <= produce;
      if (produce) begin
        busy_r  <= busy_nxt;
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
      end
    end
  end

  // payload: working record and output word
  always_ff @(posedge clk) begin
    if (adv && produce) begin
      cur_r  <= cur_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

FILE: hdl/copy_record_encoder_core.sv
// Copy record encoder: turns block-copy match records into a byte stream.
// Input side is a queue: drive in_target_block, in_source_block and
// in_block_count with push high; the word is taken on an edge where full
// is low. Output side is a queue too: while empty is low, out_byte holds
// the oldest encoded byte and out_last_byte marks the final byte of a
// record; pop high on such an edge takes it.
// Each record yields 3 to 13 bytes: a control byte, source and count
// big-endian in 1 to 4 bytes each, and the gap when it is nonzero.
// An accepted record passes through the queue and then the output byte
// register before its control byte shows. Throughput is one byte per cycle
// while pop is not held low; the byte sequencer in the back end is what
// sets that rate.
// The front end classifies a record in the cycle it is accepted and queues
// it (FIFO_DEPTH records deep); it keeps accepting while the back end works.
// When the receiver stalls, the output byte holds, the queue fills and then
// full rises. Reset clears the remembered next target to 0 and empties the
// queue and the output register.
module copy_record_encoder_core #(
  parameter int unsigned FIFO_DEPTH = cre_pkg::CRE_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_target_block,
  input  logic [31:0] in_source_block,
  input  logic [31:0] in_block_count,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);
  import cre_pkg::*;

  cre_rec_t q_wdata;
  cre_rec_t q_rdata;
  logic     q_wr;
  logic     q_rd;
  logic     q_full;
  logic     q_nonempty;

  assign full = q_full;

  cre_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_target_block (in_target_block),
    .in_source_block (in_source_block),
    .in_block_count  (in_block_count),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  cre_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd       (q_rd),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  cre_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_rdata),
    .head_valid    (q_nonempty),
    .head_rd       (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

FILE: tb/sv/cre_stream_checker.sv
`timescale 1ns / 1ps

// Watches both queue ports of the copy record encoder, predicts the byte
// stream of every accepted record and compares each popped word with it.
module cre_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] in_target_block,
  input  logic [31:0] in_source_block,
  input  logic [31:0] in_block_count,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        out_last_byte,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  enc_byte_t   expected_bytes[$];
  logic [31:0] next_tgt = '0;
  int unsigned fails = 0;

  // fewest bytes (1..4) that hold v
  function automatic int unsigned byte_len(input logic [31:0] v);
    if (v >= 32'h0100_0000) return 4;
    if (v >= 32'h0001_0000) return 3;
    if (v >= 32'h0000_0100) return 2;
    return 1;
  endfunction

  // control byte, then source, count and nonzero gap, big-endian
  task automatic encode_record(input logic [31:0] tgt, input logic [31:0] src,
                               input logic [31:0] cnt);
    logic [31:0] gap;
    logic [31:0] vals[3];
    int unsigned lens[3];
    int unsigned total;
    int unsigned k;
    logic [7:0]  ctrl;
    gap      = tgt - next_tgt;
    next_tgt = tgt + cnt;
    vals[0]  = src;
    vals[1]  = cnt;
    vals[2]  = gap;
    lens[0]  = byte_len(src);
    lens[1]  = byte_len(cnt);
    lens[2]  = (gap != 0) ? byte_len(gap) : 0;
    ctrl       = 8'h00;
    ctrl[7:6]  = 2'(lens[0] - 1);
    ctrl[5:4]  = 2'(lens[1] - 1);
    if (gap != 0) begin
      ctrl[3:2] = 2'(lens[2] - 1);
      ctrl[1]   = 1'b1;
    end
    total = 1 + lens[0] + lens[1] + lens[2];
    expected_bytes.push_back('{data: ctrl, last: 1'b0});
    k = 1;
    for (int f = 0; f < 3; f++) begin
      for (int unsigned i = lens[f]; i > 0; i--) begin
        expected_bytes.push_back('{data: vals[f][(i - 1) * 8 +: 8], last: k == total - 1});
        k++;
      end
    end
  endtask

  // compare popped words, then queue predictions for accepted records
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      next_tgt = '0;
      expected_bytes.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last_byte);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte || want.last !== out_last_byte) begin
            $display("%0t: word mismatch: expected byte %02h last %0b, actual byte %02h last %0b",
                     $time, want.data, want.last, out_byte, out_last_byte);
            fails++;
          end
        end
      end
      if (push && !full)
        encode_record(in_target_block, in_source_block, in_block_count);
    end
    pending    <= expected_bytes.size();
    fail_count <= fails;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RECORDS_PER_PHASE = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [31:0] in_target_block = '0;
  logic [31:0] in_source_block = '0;
  logic [31:0] in_block_count = '0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles = 0;
  logic [31:0] tgt_cursor = '0;

  copy_record_encoder_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_target_block(in_target_block),
    .in_source_block(in_source_block),
    .in_block_count (in_block_count),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte)
  );

  cre_stream_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_target_block(in_target_block),
    .in_source_block(in_source_block),
    .in_block_count (in_block_count),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random pop stalls
  always @(posedge clk) begin
    if (!rst_n)
      pop <= 1'b0;
    else
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one record word, with random idle cycles ahead of it
  task automatic send_record(input logic [31:0] tgt, input logic [31:0] src,
                             input logic [31:0] cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_target_block <= tgt;
    in_source_block <= src;
    in_block_count  <= cnt;
    @(posedge clk);
    while (full) @(posedge clk);
    tgt_cursor = tgt + cnt;
  endtask

  // value of random byte length, zero now and then
  function automatic logic [31:0] rand_sized();
    case ($urandom_range(0, 8))
      0:       return 32'h0;
      1, 2:    return 32'($urandom_range(1, 32'hFF));
      3, 4:    return 32'($urandom_range(32'h100, 32'hFFFF));
      5, 6:    return 32'($urandom_range(32'h1_0000, 32'hFF_FFFF));
      default: return 32'($urandom_range(32'h100_0000, 32'hFFFF_FFFF));
    endcase
  endfunction

  // mostly contiguous records or random gaps, some arbitrary targets, some zero counts
  task automatic send_random_record();
    logic [31:0] tgt;
    logic [31:0] src;
    logic [31:0] cnt;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    src  = ($urandom_range(0, 3) == 0) ? 32'($urandom) : rand_sized();
    cnt  = rand_sized();
    if (kind <= 4)
      tgt = tgt_cursor;
    else if (kind <= 7)
      tgt = tgt_cursor + rand_sized();
    else if (kind == 8)
      tgt = 32'($urandom);
    else begin
      tgt = ($urandom_range(0, 1) == 0) ? tgt_cursor : 32'($urandom);
      cnt = 32'h0;
    end
    send_record(tgt, src, cnt);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 51;

    // terminator from reset state: shortest record
    send_record(32'h0, 32'h0, 32'h0);
    // all fields at maximum: longest record, next target wraps
    send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // target below remembered block after the wrap
    send_record(32'h0, 32'h1, 32'h1);
    // byte length boundaries on source and count
    send_record(32'h1, 32'hFF, 32'hFF);
    send_record(32'h100, 32'h100, 32'h100);
    send_record(32'h200, 32'hFFFF, 32'hFFFF);
    send_record(32'h1_01FF, 32'h1_0000, 32'h1_0000);
    send_record(32'h2_01FF, 32'hFF_FFFF, 32'hFF_FFFF);
    send_record(32'h102_01FE, 32'h100_0000, 32'h100_0000);
    // nonzero gaps of one to three bytes
    send_record(32'h202_01FE + 32'hFF, 32'h5, 32'h3);
    send_record(32'h202_0204 + 32'h100, 32'h5, 32'h3);
    send_record(32'h202_0307 + 32'hFFFF, 32'h5, 32'h3);
    send_record(32'h203_0309 + 32'hFF_FFFF, 32'h5, 32'h3);
    // target before next target: huge wrapped gap
    send_record(32'h0000_0010, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_record(32'h0000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    // terminator mid-stream keeps state; the record after it is contiguous
    send_record(tgt_cursor, 32'h7, 32'h0);
    send_record(tgt_cursor, 32'h8, 32'h2);
    // pending target overflow with a small count
    send_record(32'hFFFF_FFF0, 32'h9, 32'h20);
    send_record(32'h0000_0010, 32'hA, 32'h1);

    for (int i = 0; i < RECORDS_PER_PHASE; i++) send_random_record();

    send_idle_pct = 51;
    recv_idle_pct = 33;
    for (int i = 0; i < RECORDS_PER_PHASE; i++) send_random_record();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RECORDS_PER_PHASE; i++) send_random_record();
    push <= 1'b0;

    // drain, then give stray words a chance to show
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
